// ----- src/longest_increasing_subsequence_assert.svh -----
// Assertion macros shared by the longest increasing subsequence RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LIS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LIS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lis_pkg.sv -----
// Shared constants and types for the longest increasing subsequence block.
// No dependencies.
`default_nettype none

package lis_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int PRED_W      = 7;
  localparam int LEN_W       = 7;
  localparam int OUT_W       = ((VALUE_WIDTH + LEN_W + 7) / 8) * 8;

  localparam logic [PRED_W-1:0] NO_PRED = '1;

  // one slot of the tails table
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [ADDR_W-1:0]      pos;
  } tail_ent_t;

  // one stored input item
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [PRED_W-1:0]      pred;
  } item_ent_t;

  // one result beat handed to the output stage
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   run_end;
    logic [LEN_W-1:0]       run_length;
    logic                   dropped;
  } res_t;

endpackage

`default_nettype wire

// ----- src/lis_core.sv -----
// Search, table update and backtrack sequencer with the tails and item memories.
// Depends on lis_pkg and longest_increasing_subsequence_assert.svh.
`default_nettype none

module lis_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lis_pkg::VALUE_WIDTH-1:0] in_value,
  input  wire logic                            in_last,
  output logic                                 res_load,
  input  wire logic                            res_ready,
  output lis_pkg::res_t                        res
);
  import lis_pkg::*;

  `include "longest_increasing_subsequence_assert.svh"

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEARCH = 4'd1;
  localparam logic [3:0] ST_UPDATE = 4'd2;
  localparam logic [3:0] ST_HEAD   = 4'd3;
  localparam logic [3:0] ST_WALK   = 4'd4;
  localparam logic [3:0] ST_E_TAIL = 4'd5;
  localparam logic [3:0] ST_E_ITEM = 4'd6;
  localparam logic [3:0] ST_E_LOAD = 4'd7;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [3:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       item_cnt_r, item_cnt_nxt;
  logic [CNT_W-1:0]       tail_cnt_r, tail_cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   last_r, last_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic                   eq_r, eq_nxt;
  logic [PRED_W-1:0]      prd_r, prd_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic                   first_r, first_nxt;
  logic [CNT_W-1:0]       e_r, e_nxt;

  tail_ent_t         tail_mem [MAX_ITEMS];
  item_ent_t         item_mem [MAX_ITEMS];
  tail_ent_t         tail_rd_r, tail_wd;
  item_ent_t         item_rd_r, item_wd;
  logic              tail_we, tail_re, item_we, item_re;
  logic [ADDR_W-1:0] tail_wa, tail_ra, item_wa, item_ra;

  function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W:1];
  endfunction

  // Memories: one write and one registered read per cycle; read data holds
  // until the next read so a stalled result keeps its value.
  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd_r <= tail_mem[tail_ra];
    if (item_we) item_mem[item_wa] <= item_wd;
    if (item_re) item_rd_r <= item_mem[item_ra];
  end

  always_comb begin
    logic [CNT_W-1:0]  mid, lo_n, hi_n, km1, pick;
    logic              less;
    logic [ADDR_W-1:0] idx;

    mid  = mid_of(lo_r, hi_r);
    lo_n = lo_r;
    hi_n = hi_r;
    km1  = k_r - CNT_ONE;
    pick = mid_of(CNT_W'(0), tail_cnt_r);
    less = $signed(tail_rd_r.value) < $signed(val_r);
    idx  = first_r ? tail_rd_r.pos : item_rd_r.pred[ADDR_W-1:0];

    state_nxt    = state_r;
    item_cnt_nxt = item_cnt_r;
    tail_cnt_nxt = tail_cnt_r;
    ovf_nxt      = ovf_r;
    val_nxt      = val_r;
    last_nxt     = last_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    eq_nxt       = eq_r;
    prd_nxt      = prd_r;
    k_nxt        = k_r;
    first_nxt    = first_r;
    e_nxt        = e_r;

    tail_we = 1'b0;
    tail_re = 1'b0;
    item_we = 1'b0;
    item_re = 1'b0;
    tail_wa = '0;
    tail_ra = '0;
    item_wa = '0;
    item_ra = '0;
    tail_wd = '0;
    item_wd = '0;

    in_ready = 1'b0;
    res_load = 1'b0;
    res      = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt  = in_value;
          last_nxt = in_last;
          lo_nxt   = '0;
          hi_nxt   = tail_cnt_r;
          eq_nxt   = 1'b0;
          prd_nxt  = NO_PRED;
          if (item_cnt_r == CNT_MAX) begin
            // full: drop the value, still honor the last marker
            ovf_nxt   = 1'b1;
            state_nxt = in_last ? ST_HEAD : ST_IDLE;
          end else if (tail_cnt_r == '0) begin
            state_nxt = ST_UPDATE;
          end else begin
            tail_re   = 1'b1;
            tail_ra   = pick[ADDR_W-1:0];
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (less) begin
          lo_n    = mid + CNT_ONE;
          prd_nxt = PRED_W'(tail_rd_r.pos);
        end else begin
          hi_n   = mid;
          eq_nxt = (tail_rd_r.value == val_r);
        end
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          tail_re = 1'b1;
          tail_ra = ADDR_W'(mid_of(lo_n, hi_n));
        end else begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        item_we       = 1'b1;
        item_wa       = item_cnt_r[ADDR_W-1:0];
        item_wd.value = val_r;
        item_wd.pred  = prd_r;
        if (!eq_r && (lo_r < CNT_MAX)) begin
          tail_we       = 1'b1;
          tail_wa       = lo_r[ADDR_W-1:0];
          tail_wd.value = val_r;
          tail_wd.pos   = item_cnt_r[ADDR_W-1:0];
          if (lo_r == tail_cnt_r) tail_cnt_nxt = tail_cnt_r + CNT_ONE;
        end
        item_cnt_nxt = item_cnt_r + CNT_ONE;
        state_nxt    = last_r ? ST_HEAD : ST_IDLE;
      end

      ST_HEAD: begin
        if (tail_cnt_r == '0) begin
          item_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          tail_re   = 1'b1;
          tail_ra   = ADDR_W'(tail_cnt_r - CNT_ONE);
          k_nxt     = tail_cnt_r;
          first_nxt = 1'b1;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        // tails table is dead now: reuse its position field as the reversal buffer
        tail_we     = 1'b1;
        tail_wa     = km1[ADDR_W-1:0];
        tail_wd.pos = idx;
        item_re     = 1'b1;
        item_ra     = idx;
        first_nxt   = 1'b0;
        k_nxt       = km1;
        if (k_r == CNT_ONE) begin
          e_nxt     = '0;
          state_nxt = ST_E_TAIL;
        end
      end

      ST_E_TAIL: begin
        tail_re   = 1'b1;
        tail_ra   = e_r[ADDR_W-1:0];
        state_nxt = ST_E_ITEM;
      end

      ST_E_ITEM: begin
        item_re   = 1'b1;
        item_ra   = tail_rd_r.pos;
        state_nxt = ST_E_LOAD;
      end

      ST_E_LOAD: begin
        res.value      = item_rd_r.value;
        res.run_end    = ((e_r + CNT_ONE) == tail_cnt_r);
        res.run_length = LEN_W'(tail_cnt_r);
        res.dropped    = ovf_r;
        if (res_ready) begin
          res_load = 1'b1;
          if (res.run_end) begin
            item_cnt_nxt = '0;
            tail_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            e_nxt     = e_r + CNT_ONE;
            state_nxt = ST_E_TAIL;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      item_cnt_r <= '0;
      tail_cnt_r <= '0;
      ovf_r      <= 1'b0;
      first_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      item_cnt_r <= item_cnt_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      ovf_r      <= ovf_nxt;
      first_r    <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    eq_r   <= eq_nxt;
    prd_r  <= prd_nxt;
    k_r    <= k_nxt;
    e_r    <= e_nxt;
  end

  `LIS_ASSERT_IMP(a_tails_le_items, 1'b1, tail_cnt_r <= item_cnt_r, "tail count exceeds item count")
  `LIS_ASSERT_IMP(a_search_window, state_r == ST_SEARCH, (lo_r < hi_r) && (hi_r <= tail_cnt_r), "search window out of range")
  `LIS_ASSERT_IMP(a_no_overrun, res_load, res_ready, "result loaded into a full output stage")
  `LIS_ASSERT_NXT(a_clear_after_run, res_load && res.run_end, (item_cnt_r == '0) && (tail_cnt_r == '0) && !ovf_r, "counts not cleared after run")

endmodule

`default_nettype wire

// ----- src/longest_increasing_subsequence.sv -----
// An item takes the idle state, one search step per probe of the tails memory read port,
// up to ceil(log2(tails+1)) steps, and an update step. On the last item: a head step, a
// walk over run_length predecessors, then per result a tails read, item read and load.
// A beat beyond capacity is dropped in the idle state; the next item is taken as soon
// as the last result sits in the output register. Reset (rst_n low, synchronous) clears
// counts, drop flag and output valid; memories keep contents and need no clearing pass.
`default_nettype none

module longest_increasing_subsequence (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [lis_pkg::VALUE_WIDTH-1:0] in_tdata,   // [31:0] sample_value
  input  wire logic                            in_tlast,   // final_item
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [lis_pkg::OUT_W-1:0]            out_tdata,  // [31:0] run_value, [38:32] run_length
  output logic                                 out_tlast,  // run_end
  output logic                                 out_tuser   // items_dropped
);
  import lis_pkg::*;

  logic res_load, res_ready;
  res_t res, out_r;
  logic out_valid_r;

  lis_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .res_load  (res_load),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: the core moves on while a beat waits here
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_r.run_length, out_r.value});
  assign out_tlast  = out_r.run_end;
  assign out_tuser  = out_r.dropped;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for longest_increasing_subsequence: drives sequences
// over the input stream, predicts the emitted run, and checks every result beat.
// Depends on lis_pkg and the longest_increasing_subsequence RTL.
`default_nettype none

module testbench;
  import lis_pkg::*;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_last;
  } sample_beat_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   run_end;
    logic [LEN_W-1:0]       run_length;
    logic                   dropped;
  } run_beat_t;

  typedef enum {SEQ_RANDOM, SEQ_NARROW, SEQ_RISING, SEQ_FALLING, SEQ_STRICT} seq_style_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [VALUE_WIDTH-1:0] in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [39:0]            out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  longest_increasing_subsequence u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [31:0] sample_value
    .in_tlast  (in_tlast),    // final_item
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [31:0] run_value, [38:32] run_length
    .out_tlast (out_tlast),   // run_end
    .out_tuser (out_tuser)    // items_dropped
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expected run beats
  sample_beat_t sample_queue[$];
  sample_beat_t next_sample;
  run_beat_t    run_queue[$];
  run_beat_t    want_beat;
  int           total_items    = 0;
  int           accepted_items = 0;
  int           error_count    = 0;
  int           test_phase     = 0;
  int           send_idle_pct[3] = '{22, 45, 0};
  int           recv_idle_pct[3] = '{45, 22, 0};
  int           hold_left      = 0;
  bit           hold_done      = 1'b0;

  // predictor state
  logic signed [VALUE_WIDTH-1:0] kept_values [MAX_ITEMS];
  logic signed [VALUE_WIDTH-1:0] tail_value  [MAX_ITEMS];
  logic [ADDR_W-1:0]             tail_index  [MAX_ITEMS];
  logic [PRED_W-1:0]             pred_index  [MAX_ITEMS];
  logic [ADDR_W-1:0]             run_chain   [MAX_ITEMS];
  int                            tail_len      = 0;
  int                            seq_items     = 0;
  logic                          overflow_flag = 1'b0;

  task automatic absorb_sample(input logic signed [VALUE_WIDTH-1:0] v, input logic is_last);
    int        lo, hi, mid, slot, here, len, idx;
    run_beat_t beat;
    if (seq_items >= MAX_ITEMS) begin
      overflow_flag = 1'b1;
    end else begin
      here = seq_items;
      kept_values[here] = v;
      seq_items++;
      lo = 0;
      hi = tail_len;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tail_value[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      slot = lo;
      // equal to an existing tail: table unchanged
      if (!(slot < tail_len && tail_value[slot] == v) && slot < MAX_ITEMS) begin
        pred_index[here] = (slot > 0) ? PRED_W'(tail_index[slot-1]) : NO_PRED;
        tail_value[slot] = v;
        tail_index[slot] = ADDR_W'(here);
        if (slot == tail_len) tail_len++;
      end
    end
    if (is_last) begin
      len = tail_len;
      if (len > 0) begin
        idx = tail_index[len-1];
        for (int k = len - 1; k >= 0; k--) begin
          run_chain[k] = ADDR_W'(idx);
          if (k > 0) idx = pred_index[idx];
        end
        for (int k = 0; k < len; k++) begin
          beat.value      = kept_values[run_chain[k]];
          beat.run_end    = (k == len - 1);
          beat.run_length = LEN_W'(len);
          beat.dropped    = overflow_flag;
          run_queue.push_back(beat);
        end
      end
      tail_len      = 0;
      seq_items     = 0;
      overflow_flag = 1'b0;
    end
  endtask

  task automatic push_sample(input logic [VALUE_WIDTH-1:0] v, input logic is_last);
    sample_beat_t s;
    s.value   = v;
    s.is_last = is_last;
    sample_queue.push_back(s);
  endtask

  task automatic append_sequence(input int len, input seq_style_t style);
    int v;
    v = $signed($urandom()) >>> 8;
    for (int i = 0; i < len; i++) begin
      case (style)
        SEQ_RANDOM:  v = $urandom();
        SEQ_NARROW:  v = $urandom_range(15) - 8;
        SEQ_RISING:  v = ($urandom_range(99) < 75) ? v + $urandom_range(20)
                                                   : v - $urandom_range(30);
        SEQ_FALLING: v = v - $urandom_range(50, 1);
        SEQ_STRICT:  v = v + $urandom_range(1000, 1);
        default:     v = 0;
      endcase
      push_sample(v, i == len - 1);
    end
  endtask

  task automatic check_field(input string name, input logic [VALUE_WIDTH-1:0] want,
                             input logic [VALUE_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // stimulus
  initial begin
    bit strict_done, random_done;
    strict_done = 1'b0;
    random_done = 1'b0;
    // extremes, equal-to-tail values, sign flips
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd3, 1'b0);
    push_sample(32'd7, 1'b0);
    push_sample(32'd7, 1'b0);
    push_sample(32'd6, 1'b1);
    // one-item sequences
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h7FFF_FFFF, 1'b1);
    // falling: run of one
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'd100, 1'b0);
    push_sample(-32'sd100, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'hAAAA_AAAA, 1'b0);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0001, 1'b1);
    while (sample_queue.size() < 380) begin
      if (!strict_done && sample_queue.size() > 90) begin
        // overflow: 64 rising values, the rest dropped, last marker on a dropped beat
        append_sequence(70, SEQ_STRICT);
        strict_done = 1'b1;
      end else if (!random_done && sample_queue.size() > 220) begin
        append_sequence(MAX_ITEMS, SEQ_RANDOM);
        random_done = 1'b1;
      end else begin
        append_sequence($urandom_range(12, 1), seq_style_t'($urandom_range(3)));
      end
    end
    total_items = sample_queue.size();
  end

  // reset
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      test_phase <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_sample(in_tdata, in_tlast);
        accepted_items++;
      end
      test_phase <= (accepted_items * 3 < total_items)     ? 0 :
                    (accepted_items * 3 < 2 * total_items) ? 1 : 2;
      // hold the beat until taken, then advance or idle
      if (!in_tvalid || in_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct[test_phase]) begin
          next_sample = sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_sample.value;
          in_tlast  <= next_sample.is_last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off once a result waits in the last test phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && test_phase == 2 && out_tvalid) begin
      hold_left  <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct[test_phase]);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (run_queue.size() == 0) begin
        $error("unexpected result beat: run_value %0h", out_tdata[31:0]);
        error_count++;
      end else begin
        want_beat = run_queue.pop_front();
        check_field("run_value", want_beat.value, out_tdata[31:0]);
        check_field("run_end", want_beat.run_end, out_tlast);
        check_field("run_length", want_beat.run_length, out_tdata[38:32]);
        check_field("items_dropped", want_beat.dropped, out_tuser);
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    while (total_items == 0 || sample_queue.size() != 0 || in_tvalid || run_queue.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
